[rtl/core/anbf_pkg.sv]
// ----------------------------------------------------------------------------
// anbf_pkg
// Shared sizes, constants and word types for the Annex B NAL fragmenter.
// ----------------------------------------------------------------------------
package anbf_pkg;

  // Sizing
  localparam int unsigned MAX_FRAGMENTS = 32;
  localparam int unsigned POS_W         = 24;
  localparam int unsigned LEN_W         = POS_W + 1;
  localparam int unsigned IDX_W         = 5;
  localparam int unsigned CNT_W         = $clog2(MAX_FRAGMENTS + 1);

  // Saturated byte position
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Last byte of a start code
  localparam logic [7:0] SC_MARK = 8'h01;

  // One result word
  typedef struct packed {
    logic [POS_W-1:0] frag_offset;
    logic [LEN_W-1:0] frag_length;
    logic [IDX_W-1:0] frag_index;
    logic             no_start_code;
    logic             last_fragment;
  } anbf_res_t;

  // Results caused by one input byte: a mid-frame fragment and/or the frame tail
  typedef struct packed {
    logic      mid_vld;
    anbf_res_t mid;
    logic      tail_vld;
    anbf_res_t tail;
  } anbf_pair_t;

endpackage

[rtl/core/anbf_scan.sv]
// ----------------------------------------------------------------------------
// anbf_scan
// Input register, start code search state and per-byte result logic.
// ----------------------------------------------------------------------------
module anbf_scan import anbf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_end_i,
  input  logic       full_i,
  output logic       push_o,
  output anbf_pair_t pair_o
);

  // Input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q;
  logic       fend_q;

  // Mode register
  logic mode_q;

  // Frame state
  logic [POS_W-1:0] pos_q, pos_d;
  logic [23:0]      recent_q, recent_d;
  logic             pend_vld_q, pend_vld_d;
  logic [POS_W-1:0] pend_pos_q, pend_pos_d;
  logic [LEN_W-1:0] pend_conf_q, pend_conf_d;
  logic [POS_W-1:0] pend_open_q, pend_open_d;
  logic [POS_W-1:0] open_q, open_d;
  logic [CNT_W-1:0] frags_q, frags_d;

  // Per-byte terms
  logic             proc;
  logic             conf;
  logic [POS_W-1:0] open_n;
  logic [CNT_W-1:0] frags_n;
  logic             det, det_four, det_three;
  logic [LEN_W-1:0] cur_p1, cur_p2;
  logic [POS_W-1:0] cur_sat_p1;
  logic [LEN_W-1:0] mid_len, tail_len;

  assign proc       = in_vld_q && !full_i;
  assign in_ready_o = !in_vld_q || proc;

  // Input word register
  assign in_vld_d = in_ready_o ? in_valid_i : in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
      fend_q <= frame_end_i;
    end
  end

  // Mode register; the user must write it only while idle, the block has no check for this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Pending code confirmation: four bytes after its first byte
  assign conf    = pend_vld_q && ({1'b0, pos_q} >= pend_conf_q);
  assign open_n  = conf ? pend_open_q : open_q;
  assign frags_n = conf ? frags_q + CNT_W'(1) : frags_q;

  assign mid_len = (pend_pos_q >= open_q) ? {1'b0, pend_pos_q - open_q} : '0;

  // Start code detection ending with the current byte
  assign cur_p1     = {1'b0, pos_q} + LEN_W'(1);
  assign cur_p2     = {1'b0, pos_q} + LEN_W'(2);
  assign cur_sat_p1 = (pos_q == POS_MAX) ? POS_MAX : pos_q + POS_W'(1);

  assign det       = !(pend_vld_q && !conf) && (frags_n < CNT_W'(MAX_FRAGMENTS)) &&
                     (byte_q == SC_MARK) && (recent_q[15:0] == 16'h0000);
  assign det_four  = det && (recent_q[23:16] == 8'h00) && (pos_q >= POS_W'(3));
  assign det_three = det && !det_four && (pos_q >= POS_W'(2));

  // Tail length up to the end of the frame
  assign tail_len = (cur_p1 >= {1'b0, open_n}) ? cur_p1 - {1'b0, open_n} : '0;

  // Result words
  always_comb begin
    pair_o.mid_vld            = conf && (frags_q != '0) && !mode_q;
    pair_o.mid.frag_offset    = open_q;
    pair_o.mid.frag_length    = mid_len;
    pair_o.mid.frag_index     = IDX_W'(frags_q - CNT_W'(1));
    pair_o.mid.no_start_code  = 1'b0;
    pair_o.mid.last_fragment  = 1'b0;

    pair_o.tail_vld           = fend_q;
    pair_o.tail.last_fragment = 1'b1;
    if (mode_q) begin
      pair_o.tail.frag_offset   = '0;
      pair_o.tail.frag_length   = cur_p1;
      pair_o.tail.frag_index    = '0;
      pair_o.tail.no_start_code = 1'b0;
    end else if (frags_n != '0) begin
      pair_o.tail.frag_offset   = open_n;
      pair_o.tail.frag_length   = tail_len;
      pair_o.tail.frag_index    = IDX_W'(frags_n - CNT_W'(1));
      pair_o.tail.no_start_code = 1'b0;
    end else begin
      pair_o.tail.frag_offset   = '0;
      pair_o.tail.frag_length   = '0;
      pair_o.tail.frag_index    = '0;
      pair_o.tail.no_start_code = 1'b1;
    end
  end

  assign push_o = proc && (pair_o.mid_vld || pair_o.tail_vld);

  // Next frame state
  always_comb begin
    pos_d       = pos_q;
    recent_d    = recent_q;
    pend_vld_d  = pend_vld_q;
    pend_pos_d  = pend_pos_q;
    pend_conf_d = pend_conf_q;
    pend_open_d = pend_open_q;
    open_d      = open_q;
    frags_d     = frags_q;
    if (proc) begin
      open_d     = open_n;
      frags_d    = frags_n;
      pend_vld_d = pend_vld_q && !conf;
      if (det_four) begin
        pend_vld_d  = 1'b1;
        pend_pos_d  = pos_q - POS_W'(3);
        pend_conf_d = cur_p1;
        pend_open_d = cur_sat_p1;
      end else if (det_three) begin
        pend_vld_d  = 1'b1;
        pend_pos_d  = pos_q - POS_W'(2);
        pend_conf_d = cur_p2;
        pend_open_d = cur_sat_p1;
      end
      recent_d = {recent_q[15:0], byte_q};
      pos_d    = cur_sat_p1;
      // frame done: back to the idle frame state
      if (fend_q) begin
        pos_d       = '0;
        recent_d    = 24'hFFFFFF;
        pend_vld_d  = 1'b0;
        pend_pos_d  = '0;
        pend_conf_d = '0;
        pend_open_d = '0;
        open_d      = '0;
        frags_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      recent_q    <= 24'hFFFFFF;
      pend_vld_q  <= 1'b0;
      pend_pos_q  <= '0;
      pend_conf_q <= '0;
      pend_open_q <= '0;
      open_q      <= '0;
      frags_q     <= '0;
    end else begin
      pos_q       <= pos_d;
      recent_q    <= recent_d;
      pend_vld_q  <= pend_vld_d;
      pend_pos_q  <= pend_pos_d;
      pend_conf_q <= pend_conf_d;
      pend_open_q <= pend_open_d;
      open_q      <= open_d;
      frags_q     <= frags_d;
    end
  end

endmodule

[rtl/core/anbf_res_queue.sv]
// ----------------------------------------------------------------------------
// anbf_res_queue
// Two-entry queue of per-byte result pairs, sent out one word at a time.
// ----------------------------------------------------------------------------
module anbf_res_queue import anbf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  anbf_pair_t pair_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output anbf_res_t  res_o
);

  anbf_pair_t q_mem [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       half_q, half_d;

  anbf_pair_t head;
  logic       sel_mid;
  logic       pop_word, pop_entry;

  assign head        = q_mem[rptr_q];
  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);

  // Mid-frame word goes first, the tail word after it
  assign sel_mid   = head.mid_vld && !half_q;
  assign res_o     = sel_mid ? head.mid : head.tail;
  assign pop_word  = out_valid_o && out_ready_i;
  assign pop_entry = pop_word && !(sel_mid && head.tail_vld);
  assign half_d    = pop_word ? !pop_entry : half_q;

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_entry})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wptr_q] <= pair_i;
    end
  end

  // Pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
      half_q <= 1'b0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_entry) begin
        rptr_q <= !rptr_q;
      end
      cnt_q  <= cnt_d;
      half_q <= half_d;
    end
  end

endmodule

[rtl/core/annexb_nal_fragmenter_top.sv]
// ----------------------------------------------------------------------------
// annexb_nal_fragmenter_top
// Splits an Annex B byte stream into NAL unit fragments (offset, length).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) moves one frame byte per word, with
//   frame_end_i set on the frame's last byte. Output channel
//   (out_valid_o/out_ready_i) moves one fragment word: payload offset and
//   length, fragment index, no-start-code error flag and last-fragment flag.
//   The config channel (cfg_valid_i/cfg_data_i) sets single-fragment mode;
//   write it only between frames. cfg_ready_o is always high.
// Flow: an accepted byte is registered in the input register and scanned from
//   there; any word it causes goes into the result queue, which drives the output.
// Throughput: one byte per cycle unless the result queue is full. A byte that
//   both closes a fragment and ends the frame gives two words, sent in turn.
// Reset: clears the search state, the result queue and the mode register.
// Stall: the result queue holds two byte results; when it is full the scan
//   stage holds its byte and in_ready_o drops, without a combinational path
//   from out_ready_i.
// ----------------------------------------------------------------------------
module annexb_nal_fragmenter_top import anbf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             frame_end_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [POS_W-1:0] frag_offset_o,
  output logic [LEN_W-1:0] frag_length_o,
  output logic [IDX_W-1:0] frag_index_o,
  output logic             no_start_code_o,
  output logic             last_fragment_o
);

  logic       push;
  logic       full;
  anbf_pair_t pair;
  anbf_res_t  res;

  assign cfg_ready_o = 1'b1;

  // Scan stage
  anbf_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .frame_end_i (frame_end_i),
    .full_i      (full),
    .push_o      (push),
    .pair_o      (pair)
  );

  // Result queue
  anbf_res_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pair_i      (pair),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign frag_offset_o   = res.frag_offset;
  assign frag_length_o   = res.frag_length;
  assign frag_index_o    = res.frag_index;
  assign no_start_code_o = res.no_start_code;
  assign last_fragment_o = res.last_fragment;

endmodule

[rtl/core/anbf_checker.sv]
// ----------------------------------------------------------------------------
// anbf_checker
// Port-level checks on the fragmenter, bound to the top level.
// ----------------------------------------------------------------------------
module anbf_checker import anbf_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [POS_W-1:0] frag_offset_o,
  input logic [LEN_W-1:0] frag_length_o,
  input logic [IDX_W-1:0] frag_index_o,
  input logic             no_start_code_o,
  input logic             last_fragment_o
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frag_offset_o) &&
    $stable(frag_length_o) && $stable(frag_index_o) &&
    $stable(no_start_code_o) && $stable(last_fragment_o))
    else $error("output word changed while stalled");

  // Error word is the frame's last word and carries zeros
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_start_code_o |-> last_fragment_o && (frag_offset_o == '0) &&
    (frag_length_o == '0) && (frag_index_o == '0))
    else $error("malformed no-start-code word");

  // Mid-frame words are never error words
  a_mid_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_fragment_o |-> !no_start_code_o)
    else $error("error flag on a mid-frame word");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind annexb_nal_fragmenter_top anbf_checker u_anbf_checker (.*);

[tb/annexb_nal_fragmenter_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// annexb_nal_fragmenter_top_tb
// Self-checking bench for the Annex B NAL fragmenter. Frames go in one byte
// word at a time. A scoreboard tracks the start-code search per byte and
// queues the fragment words each byte should produce. Every output word is
// checked field by field in order. The run steps through both fragment modes,
// with random idle bursts on input and output but for the closing stretch.
// ----------------------------------------------------------------------------
module annexb_nal_fragmenter_top_tb;
  import anbf_pkg::*;

  localparam int unsigned CLK_PERIOD = 10;
  localparam int unsigned LIMIT_NS   = 5_000_000;
  localparam int unsigned SHORT_CODE = 3;  // 00 00 01
  localparam int unsigned LONG_CODE  = 4;  // 00 00 00 01
  localparam int unsigned CONFIRM_AT = 4;  // bytes past a code's first byte
  localparam int unsigned MAX_SHOWN  = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  typedef enum int unsigned {
    FR_WELL,   // leading junk, then start codes with random payloads
    FR_NOISE,  // bytes only, zeros and marks frequent
    FR_CUT,    // well-formed frame cut short anywhere
    FR_MANY,   // start codes from two under to six over the fragment limit
    FR_TINY    // one or two bytes
  } frame_kind_e;

  // DUT signals
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic             cfg_data_i  = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [7:0]       data_byte_i = 8'h00;
  logic             frame_end_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [POS_W-1:0] frag_offset_o;
  logic [LEN_W-1:0] frag_length_o;
  logic [IDX_W-1:0] frag_index_o;
  logic             no_start_code_o;
  logic             last_fragment_o;

  // Stimulus and scoreboard
  stream_byte_t byte_q[$];
  logic [7:0]   frame_buf[$];
  anbf_res_t    frag_q[$];
  int unsigned  queued_bytes = 0;
  int unsigned  mismatch_cnt = 0;
  bit           idle_en      = 1'b1;
  int unsigned  send_gap     = 0;
  int unsigned  recv_gap     = 0;
  stream_byte_t next_word;
  anbf_res_t    got_frag;
  anbf_res_t    want_frag;

  // Search state mirror
  bit               sfm_mode = 1'b0;
  bit [POS_W-1:0]   pos_q;
  bit [23:0]        last3;
  bit [POS_W-1:0]   code_pos;
  bit [2:0]         code_len;
  bit [POS_W-1:0]   nal_off;
  bit [CNT_W-1:0]   nal_cnt;

  annexb_nal_fragmenter_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .frame_end_i     (frame_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frag_offset_o   (frag_offset_o),
    .frag_length_o   (frag_length_o),
    .frag_index_o    (frag_index_o),
    .no_start_code_o (no_start_code_o),
    .last_fragment_o (last_fragment_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Fragment prediction
  // ---------------------------------------------------------------------------
  function automatic void clear_frame();
    pos_q    = '0;
    last3    = 24'hFF_FFFF;
    code_pos = '0;
    code_len = '0;
    nal_off  = '0;
    nal_cnt  = '0;
  endfunction

  function automatic bit [POS_W-1:0] clip_pos(longint unsigned v);
    return (v > POS_MAX) ? POS_MAX : v[POS_W-1:0];
  endfunction

  function automatic void add_frag(longint unsigned off, longint unsigned len,
                                   int unsigned idx, bit err, bit fin);
    anbf_res_t r;
    r.frag_offset   = off[POS_W-1:0];
    r.frag_length   = len[LEN_W-1:0];
    r.frag_index    = idx[IDX_W-1:0];
    r.no_start_code = err;
    r.last_fragment = fin;
    frag_q.push_back(r);
  endfunction

  // Advance the search by one accepted byte, queueing any fragment it closes
  function automatic void scan_byte(bit [7:0] b, bit frame_last);
    longint unsigned cur;
    longint unsigned len;
    cur = pos_q;

    // a pending code counts once the byte CONFIRM_AT past its start shows up
    if (code_len != 0 && cur >= code_pos + 64'(CONFIRM_AT)) begin
      if (nal_cnt != 0 && !sfm_mode) begin
        len = (code_pos >= nal_off) ? code_pos - nal_off : 0;
        add_frag(nal_off, len, nal_cnt - 1, 1'b0, 1'b0);
      end
      nal_off  = clip_pos(64'(code_pos) + code_len);
      nal_cnt  = nal_cnt + 1'b1;
      code_len = '0;
    end

    // new start code ending on this byte; a third zero makes it the long form
    if (code_len == 0 && nal_cnt < MAX_FRAGMENTS && b == SC_MARK &&
        last3[15:0] == 16'h0000) begin
      if (last3[23:16] == 8'h00 && cur >= 3) begin
        code_pos = POS_W'(cur - 3);
        code_len = 3'(LONG_CODE);
      end else if (cur >= 2) begin
        code_pos = POS_W'(cur - 2);
        code_len = 3'(SHORT_CODE);
      end
    end
    last3 = {last3[15:0], b};

    if (frame_last) begin
      len = cur + 1;
      if (sfm_mode) begin
        add_frag(0, len, 0, 1'b0, 1'b1);
      end else if (nal_cnt != 0) begin
        add_frag(nal_off, (len >= nal_off) ? len - nal_off : 0, nal_cnt - 1, 1'b0, 1'b1);
      end else begin
        add_frag(0, 0, 0, 1'b1, 1'b1);
      end
      clear_frame();
    end else begin
      pos_q = (cur < POS_MAX) ? POS_W'(cur + 1) : POS_MAX;
    end
  endfunction

  initial clear_frame();

  // ---------------------------------------------------------------------------
  // Input driver: one byte word per handshake, random idle bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        scan_byte(data_byte_i, frame_end_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (byte_q.size() != 0) begin
          next_word = byte_q.pop_front();
          in_valid_i  <= 1'b1;
          data_byte_i <= next_word.data;
          frame_end_i <= next_word.last;
          if (idle_en && $urandom_range(0, 11) == 0) begin
            send_gap = $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: in-order compare, random back-pressure bursts
  // ---------------------------------------------------------------------------
  function automatic void log_error(string what, anbf_res_t want, anbf_res_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_SHOWN) begin
      $display("%0t: %s", $time, what);
      $display("  exp off=%0d len=%0d idx=%0d nsc=%0b last=%0b", want.frag_offset,
               want.frag_length, want.frag_index, want.no_start_code, want.last_fragment);
      $display("  got off=%0d len=%0d idx=%0d nsc=%0b last=%0b", got.frag_offset,
               got.frag_length, got.frag_index, got.no_start_code, got.last_fragment);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got_frag = '{frag_offset_o, frag_length_o, frag_index_o, no_start_code_o,
                     last_fragment_o};
        if (frag_q.size() == 0) begin
          log_error("fragment word with nothing pending", '0, got_frag);
        end else begin
          want_frag = frag_q.pop_front();
          if (got_frag.frag_offset !== want_frag.frag_offset ||
              got_frag.frag_length !== want_frag.frag_length ||
              got_frag.frag_index !== want_frag.frag_index ||
              got_frag.no_start_code !== want_frag.no_start_code ||
              got_frag.last_fragment !== want_frag.last_fragment) begin
            log_error("fragment word mismatch", want_frag, got_frag);
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 15) == 0) begin
        recv_gap = $urandom_range(0, 11);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Frame generation
  // ---------------------------------------------------------------------------
  function automatic void queue_frame();
    stream_byte_t w;
    foreach (frame_buf[i]) begin
      w.data = frame_buf[i];
      w.last = (i == frame_buf.size() - 1);
      byte_q.push_back(w);
    end
    queued_bytes += frame_buf.size();
    frame_buf.delete();
  endfunction

  // zeros and marks are common so that stray and overlapping codes show up
  function automatic logic [7:0] payload_byte();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 20) return 8'h00;
    if (p < 28) return SC_MARK;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_payload(int unsigned n);
    repeat (n) frame_buf.push_back(payload_byte());
  endfunction

  function automatic void add_code(bit long_form);
    if (long_form) frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(SC_MARK);
  endfunction

  function automatic frame_kind_e pick_kind();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return FR_WELL;
    if (p < 75) return FR_NOISE;
    if (p < 90) return FR_CUT;
    if (p < 94) return FR_MANY;
    return FR_TINY;
  endfunction

  function automatic void gen_frame(frame_kind_e kind);
    int unsigned keep;
    case (kind)
      FR_WELL, FR_CUT: begin
        add_payload($urandom_range(0, 3));
        repeat ($urandom_range(1, 6)) begin
          add_code($urandom_range(0, 1));
          add_payload($urandom_range(0, 10));
        end
        if (kind == FR_CUT) begin
          keep = $urandom_range(1, frame_buf.size());
          while (frame_buf.size() > keep) void'(frame_buf.pop_back());
        end
      end
      FR_NOISE: add_payload($urandom_range(1, 30));
      FR_MANY: begin
        repeat ($urandom_range(MAX_FRAGMENTS - 2, MAX_FRAGMENTS + 6)) begin
          add_code($urandom_range(0, 1));
          add_payload($urandom_range(0, 2));
        end
        add_payload($urandom_range(0, 5));
      end
      default: add_payload($urandom_range(1, 2));
    endcase
    queue_frame();
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  // hold off until the pipe is empty, then allow the scan stage to settle
  task automatic drain();
    do @(negedge clk_i); while (byte_q.size() != 0 || in_valid_i || frag_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_mode(bit value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sfm_mode = value;
    @(negedge clk_i);
  endtask

  task automatic run_random(int unsigned n_bytes);
    int unsigned stop_at;
    stop_at = queued_bytes + n_bytes;
    gen_frame(FR_MANY);
    while (queued_bytes < stop_at) begin
      gen_frame(pick_kind());
      if ($urandom_range(0, 24) == 0) drain();
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed frames, search mode
    write_mode(1'b0);
    // single byte, no code
    frame_buf = '{8'hFF};
    queue_frame();
    // short code right at the five-byte limit
    frame_buf = '{8'h00, 8'h00, 8'h01, 8'hAA, 8'hBB};
    queue_frame();
    // code too close to the end is dropped
    frame_buf = '{8'h00, 8'h00, 8'h01, 8'hAA};
    queue_frame();
    // long code with one payload byte
    frame_buf = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h80};
    queue_frame();
    // short code then long code, closing a mid-frame fragment
    frame_buf = '{8'h00, 8'h00, 8'h01, 8'h11, 8'h00, 8'h00, 8'h00, 8'h01,
                  8'hFE, 8'h01};
    queue_frame();
    drain();

    write_mode(1'b1);
    run_random(250);
    write_mode(1'b0);
    run_random(500);
    write_mode(1'b1);
    run_random(100);
    write_mode(1'b0);

    // closing stretch at full rate
    idle_en = 1'b0;
    run_random(400);

    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && frag_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #LIMIT_NS;
    $display("status: fail");
    $finish;
  end

endmodule
